// ===== hw/rtl/icmp_chk_pkg.sv =====
// icmp_chk_pkg: request and result types, message codes and a checksum helper
// for the icmp echo reply checker; no dependencies
package icmp_chk_pkg;

	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

	localparam logic [7:0] ICMP_TYPE_ECHO_REPLY = 8'd0;
	localparam logic [7:0] ICMP_TYPE_DEST_UNREACH = 8'd3;
	localparam logic [7:0] ICMP_TYPE_TIME_EXCEEDED = 8'd11;

	localparam logic [1:0] KIND_ECHO_REPLY = 2'd0;
	localparam logic [1:0] KIND_DEST_UNREACH = 2'd1;
	localparam logic [1:0] KIND_TIME_EXCEEDED = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;

	localparam logic REG_ECHO_ID = 1'b0;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] expected_seq;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        checksum_ok;
		logic        data_ok;
		logic        corrupted;
		logic [7:0]  icmp_code;
		logic [7:0]  ip_ttl;
		logic [31:0] reply_total;
		logic [31:0] corrupt_total;
	} out_item_t;

	// end-around carry of a ones'-complement sum held in 17 bits
	function automatic logic [16:0] fold17(input logic [16:0] x);
		logic [16:0] r;
		r = {1'b0, x[15:0]} + {16'b0, x[16]};
		return r;
	endfunction

endpackage

// ===== hw/rtl/icmp_echo_reply_checker_unit.sv =====
// icmp_echo_reply_checker_unit: byte-serial icmp echo reply checker, top level
// depends on icmp_chk_pkg
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one packet byte per request,
//   last_byte marks the final byte; expected_seq is sampled on the first byte.
//   out channel (out_valid/out_ready/out_data) gives one result per packet,
//   on its last byte: message kind, checksum and data flags, code, ttl and the
//   running reply and corruption counts.
//   config: apb port, register echo_identifier at byte address 0.
// timing:
//   one byte per clock sustained; a request is registered in the input stage,
//   and the result register raises out_valid when a last byte leaves that stage.
//   the single byte update (checksum accumulate, field capture) sets the rate.
//   while a result waits, non-final bytes keep flowing; only a further last
//   byte stalls in the input stage until out_ready takes the pending result.
// reset:
//   arst_n clears the byte position, counters, valids and echo_identifier;
//   the first byte after reset starts a new packet.
module icmp_echo_reply_checker_unit #(
	parameter int unsigned TIMESTAMP_BYTES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  icmp_chk_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output icmp_chk_pkg::out_item_t out_data,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import icmp_chk_pkg::*;

	localparam logic [POS_W-1:0] DATA_START = POS_W'(8 + TIMESTAMP_BYTES);

	logic [15:0] echo_id_q;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      load_out;
	logic      out_valid_q;
	out_item_t out_data_q;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [5:0]  hl_q, hl_b;
	logic [7:0]  ttl_q, ttl_b, ttl_n;
	logic [7:0]  type_q, type_b, type_n;
	logic [7:0]  code_q, code_b, code_n;
	logic [15:0] ident_q, ident_b, ident_n;
	logic [15:0] seq_q, seq_b, seq_n;
	logic [15:0] await_q, await_b;
	logic [15:0] cks_q, cks_b, cks_n;
	logic [16:0] sum_q, sum_b, sum_n;
	logic [7:0]  odd_q, odd_b, odd_n;
	logic        good_q, good_b, good_n;
	logic [31:0] reply_q, reply_n;
	logic [31:0] corrupt_q, corrupt_n;

	logic        first;
	logic [7:0]  b;
	logic        in_icmp;
	logic [POS_W-1:0] o;
	logic [7:0]  v;
	logic [16:0] fin_sum, fin_add;
	logic [15:0] fin_fold;
	logic [15:0] calc;
	logic        cs_ok, full, corrupt_c;
	logic [1:0]  kind_c;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_id_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_ECHO_ID)) begin
			echo_id_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ECHO_ID) begin
			prdata = {16'b0, echo_id_q};
		end
	end

	// handshake
	assign advance  = valid_s1 && (!item_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign load_out = advance && item_s1.last_byte;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// packet start clears the per-packet fields
	assign b     = item_s1.data_byte;
	assign first = (pos_q == '0);

	always_comb begin
		hl_b    = first ? {b[3:0], 2'b00} : hl_q;
		ttl_b   = first ? 8'd0 : ttl_q;
		type_b  = first ? 8'd0 : type_q;
		code_b  = first ? 8'd0 : code_q;
		ident_b = first ? 16'd0 : ident_q;
		seq_b   = first ? 16'd0 : seq_q;
		await_b = first ? item_s1.expected_seq : await_q;
		cks_b   = first ? 16'd0 : cks_q;
		sum_b   = first ? 17'd0 : sum_q;
		odd_b   = first ? 8'd0 : odd_q;
		good_b  = first ? 1'b1 : good_q;
	end

	assign in_icmp = (pos_q >= {11'b0, hl_b});
	assign o       = pos_q - {11'b0, hl_b};
	assign v       = ((o == 17'd2) || (o == 17'd3)) ? 8'd0 : b;

	// byte update
	always_comb begin
		pos_n   = pos_q;
		ttl_n   = ttl_b;
		type_n  = type_b;
		code_n  = code_b;
		ident_n = ident_b;
		seq_n   = seq_b;
		cks_n   = cks_b;
		sum_n   = sum_b;
		odd_n   = odd_b;
		good_n  = good_b;
		if (pos_q != POS_MAX) begin
			pos_n = pos_q + 17'd1;
			if (pos_q == 17'd8) begin
				ttl_n = b;
			end
			if (in_icmp) begin
				case (o)
					17'd0: type_n = b;
					17'd1: code_n = b;
					17'd2: cks_n[7:0] = b;
					17'd3: cks_n[15:8] = b;
					17'd4: ident_n[7:0] = b;
					17'd5: ident_n[15:8] = b;
					17'd6: seq_n[7:0] = b;
					17'd7: seq_n[15:8] = b;
					default: ;
				endcase
				if (!o[0]) begin
					odd_n = v;
				end else begin
					sum_n = fold17(sum_b + {1'b0, v, odd_b});
					odd_n = 8'd0;
				end
				if ((o >= DATA_START) && (b != (o[7:0] - DATA_START[7:0]))) begin
					good_n = 1'b0;
				end
			end
		end
	end

	// end of packet: one add straight from the stored sum, padded odd byte included
	always_comb begin
		fin_add = {9'b0, odd_b};
		if ((pos_q != POS_MAX) && in_icmp) begin
			fin_add = o[0] ? {1'b0, v, odd_b} : {9'b0, v};
		end
	end

	assign fin_sum  = fold17(sum_b + fin_add);
	assign fin_fold = {fin_sum[15:1], fin_sum[0] | fin_sum[16]};
	assign calc     = ~fin_fold;
	assign cs_ok    = (calc == cks_n);
	assign full     = (pos_q >= ({11'b0, hl_b} + 17'd7));

	always_comb begin
		if (!full) begin
			kind_c = KIND_OTHER;
		end else if ((type_n == ICMP_TYPE_ECHO_REPLY) && (ident_n == echo_id_q)
				&& (seq_n == await_b)) begin
			kind_c = KIND_ECHO_REPLY;
		end else if (type_n == ICMP_TYPE_DEST_UNREACH) begin
			kind_c = KIND_DEST_UNREACH;
		end else if (type_n == ICMP_TYPE_TIME_EXCEEDED) begin
			kind_c = KIND_TIME_EXCEEDED;
		end else begin
			kind_c = KIND_OTHER;
		end
	end

	assign corrupt_c = (kind_c == KIND_ECHO_REPLY) && !(cs_ok && good_n);
	assign reply_n   = reply_q + {31'b0, (kind_c == KIND_ECHO_REPLY)};
	assign corrupt_n = corrupt_q + {31'b0, corrupt_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			reply_q   <= '0;
			corrupt_q <= '0;
		end else if (advance) begin
			pos_q <= item_s1.last_byte ? '0 : pos_n;
			if (item_s1.last_byte) begin
				reply_q   <= reply_n;
				corrupt_q <= corrupt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hl_q    <= hl_b;
			ttl_q   <= ttl_n;
			type_q  <= type_n;
			code_q  <= code_n;
			ident_q <= ident_n;
			seq_q   <= seq_n;
			await_q <= await_b;
			cks_q   <= cks_n;
			sum_q   <= sum_n;
			odd_q   <= item_s1.last_byte ? 8'd0 : odd_n;
			good_q  <= good_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.kind          <= kind_c;
			out_data_q.checksum_ok   <= cs_ok;
			out_data_q.data_ok       <= good_n;
			out_data_q.corrupted     <= corrupt_c;
			out_data_q.icmp_code     <= code_n;
			out_data_q.ip_ttl        <= ttl_n;
			out_data_q.reply_total   <= reply_n;
			out_data_q.corrupt_total <= corrupt_n;
		end
	end

	// checks
	a_corrupt_is_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_data_q.corrupted || (out_data_q.kind == KIND_ECHO_REPLY)))
		else $error("corrupted flag on a non matching message");

	a_reply_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (kind_c == KIND_ECHO_REPLY)) |=> (reply_q == $past(reply_q) + 32'd1))
		else $error("reply counter did not advance on a matching reply");

	a_corrupt_with_reply: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(corrupt_q) |-> !$stable(reply_q))
		else $error("corrupt counter moved without a reply");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (out_valid_q && !out_ready && item_s1.last_byte))
		else $error("input stage stalled without a pending result");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (pos_q == '0))
		else $error("byte position not cleared after last byte");

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for icmp_echo_reply_checker_unit, byte-serial packets in,
// one verdict per packet out, predicted in-bench and compared field by field
// depends on icmp_chk_pkg and icmp_echo_reply_checker_unit
module testbench;
	import icmp_chk_pkg::*;

	localparam int STAMP_LEN = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [2:0] ECHO_ID_ADDR = {REG_ECHO_ID, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int sent_bytes = 0;
	int got_results = 0;
	int fails = 0;
	int cycle_count = 0;

	// predicted block state
	logic [15:0] echo_id_m = '0;
	logic [16:0] pos_m = '0;
	logic [5:0]  hlen_m = '0;
	logic [7:0]  ttl_m = '0;
	logic [7:0]  type_m = '0;
	logic [7:0]  code_m = '0;
	logic [7:0]  odd_m = '0;
	logic [15:0] ident_m = '0;
	logic [15:0] seq_m = '0;
	logic [15:0] await_m = '0;
	logic [15:0] csum_m = '0;
	logic [31:0] sum_m = '0;
	logic        pattern_m = 1'b1;
	logic [31:0] replies_m = '0;
	logic [31:0] corrupts_m = '0;

	out_item_t  verdict_q[$];
	out_item_t  want;
	logic [7:0] frame[$];

	icmp_echo_reply_checker_unit #(
		.TIMESTAMP_BYTES(STAMP_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [31:0] ones_add(input logic [31:0] acc, input logic [15:0] w);
		logic [31:0] t;
		t = acc + {16'h0000, w};
		return (t & 32'hFFFF) + (t >> 16);
	endfunction

	task automatic track_byte(input in_item_t it);
		logic [16:0] p;
		logic [16:0] o;
		logic [7:0]  b;
		logic [7:0]  v;
		logic [31:0] s;
		logic [15:0] calc;
		out_item_t   r;
		p = pos_m;
		b = it.data_byte;
		if (p == 0) begin
			ttl_m = '0;
			type_m = '0;
			code_m = '0;
			ident_m = '0;
			seq_m = '0;
			csum_m = '0;
			sum_m = '0;
			odd_m = '0;
			pattern_m = 1'b1;
			await_m = it.expected_seq;
			hlen_m = {b[3:0], 2'b00};
		end
		if (p < POS_MAX) begin
			if (p == 8)
				ttl_m = b;
			if (p >= hlen_m) begin
				o = p - hlen_m;
				case (o)
					0: type_m = b;
					1: code_m = b;
					2: csum_m[7:0] = b;
					3: csum_m[15:8] = b;
					4: ident_m[7:0] = b;
					5: ident_m[15:8] = b;
					6: seq_m[7:0] = b;
					7: seq_m[15:8] = b;
					default: ;
				endcase
				v = (o == 2 || o == 3) ? 8'h00 : b;
				if (!o[0]) begin
					odd_m = v;
				end else begin
					sum_m = ones_add(sum_m, {v, odd_m});
					odd_m = '0;
				end
				if (o >= 8 + STAMP_LEN && b != 8'(o - 8 - STAMP_LEN))
					pattern_m = 1'b0;
			end
			pos_m = p + 17'd1;
		end
		if (it.last_byte) begin
			sum_m = ones_add(sum_m, {8'h00, odd_m});
			odd_m = '0;
			s = (sum_m & 32'hFFFF) + (sum_m >> 16);
			s = (s & 32'hFFFF) + (s >> 16);
			calc = ~s[15:0];
			r.checksum_ok = (calc == csum_m);
			r.data_ok = pattern_m;
			if (p < hlen_m + 7)
				r.kind = KIND_OTHER;
			else if (type_m == ICMP_TYPE_ECHO_REPLY && ident_m == echo_id_m && seq_m == await_m)
				r.kind = KIND_ECHO_REPLY;
			else if (type_m == ICMP_TYPE_DEST_UNREACH)
				r.kind = KIND_DEST_UNREACH;
			else if (type_m == ICMP_TYPE_TIME_EXCEEDED)
				r.kind = KIND_TIME_EXCEEDED;
			else
				r.kind = KIND_OTHER;
			r.corrupted = 1'b0;
			if (r.kind == KIND_ECHO_REPLY) begin
				replies_m = replies_m + 1;
				if (!(r.checksum_ok && r.data_ok)) begin
					r.corrupted = 1'b1;
					corrupts_m = corrupts_m + 1;
				end
			end
			r.icmp_code = code_m;
			r.ip_ttl = ttl_m;
			r.reply_total = replies_m;
			r.corrupt_total = corrupts_m;
			verdict_q.push_back(r);
			pos_m = '0;
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s expected %0h actual %0h", name, exp_v, act_v);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_results++;
			if (verdict_q.size() == 0) begin
				$error("result with nothing expected: %p", out_data);
				fails++;
			end else begin
				want = verdict_q.pop_front();
				check_field("kind", 32'(want.kind), 32'(out_data.kind));
				check_field("checksum_ok", 32'(want.checksum_ok), 32'(out_data.checksum_ok));
				check_field("data_ok", 32'(want.data_ok), 32'(out_data.data_ok));
				check_field("corrupted", 32'(want.corrupted), 32'(out_data.corrupted));
				check_field("icmp_code", 32'(want.icmp_code), 32'(out_data.icmp_code));
				check_field("ip_ttl", 32'(want.ip_ttl), 32'(out_data.ip_ttl));
				check_field("reply_total", want.reply_total, out_data.reply_total);
				check_field("corrupt_total", want.corrupt_total, out_data.corrupt_total);
			end
		end
	end

	// receive side: long hold-off first, else random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_byte(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_byte(it);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] seq);
		in_item_t it;
		for (int i = 0; i < frame.size(); i++) begin
			it.data_byte = frame[i];
			it.last_byte = (i == frame.size() - 1);
			it.expected_seq = (i == 0) ? seq : 16'($urandom);
			send_byte(it);
		end
	endtask

	function automatic void build_frame(input int hwords, input logic [7:0] ty,
		input logic [7:0] code, input logic [15:0] ident, input logic [15:0] seq,
		input int pay_len, input bit good_csum);
		logic [7:0]  msg[$];
		logic [7:0]  hi;
		logic [31:0] acc;
		logic [15:0] word;
		msg = {ty, code, 8'h00, 8'h00, ident[7:0], ident[15:8], seq[7:0], seq[15:8]};
		for (int i = 0; i < pay_len; i++)
			msg.push_back(i < STAMP_LEN ? 8'($urandom) : 8'(i - STAMP_LEN));
		acc = '0;
		for (int i = 0; i < msg.size(); i += 2) begin
			hi = (i + 1 < msg.size()) ? msg[i + 1] : 8'h00;
			acc = ones_add(acc, {hi, msg[i]});
		end
		word = good_csum ? ~acc[15:0] : 16'($urandom);
		msg[2] = word[7:0];
		msg[3] = word[15:8];
		frame.delete();
		for (int i = 0; i < hwords * 4; i++)
			frame.push_back(8'($urandom));
		if (hwords > 0)
			frame[0] = {frame[0][7:4], 4'(hwords)};
		for (int i = 0; i < msg.size(); i++)
			frame.push_back(msg[i]);
	endfunction

	task automatic send_random_frame();
		int pick;
		int hwords;
		int pay;
		int cut;
		logic [15:0] seq;
		logic [15:0] ident;
		logic [15:0] seq_in_msg;
		logic [7:0]  ty;
		pick = $urandom_range(99);
		hwords = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
		pay = ($urandom_range(5) == 0) ? $urandom_range(STAMP_LEN + 40)
			: $urandom_range(STAMP_LEN + 6);
		seq = 16'($urandom);
		ident = echo_id_m;
		seq_in_msg = seq;
		ty = ICMP_TYPE_ECHO_REPLY;
		if (pick >= 55 && pick < 63)
			ident = ident ^ 16'($urandom_range(65535, 1));
		else if (pick >= 63 && pick < 70)
			seq_in_msg = seq ^ 16'($urandom_range(65535, 1));
		else if (pick >= 70 && pick < 78)
			ty = ICMP_TYPE_DEST_UNREACH;
		else if (pick >= 78 && pick < 84)
			ty = ICMP_TYPE_TIME_EXCEEDED;
		else if (pick >= 84 && pick < 90)
			ty = 8'($urandom);
		build_frame(hwords, ty, 8'($urandom), ident, seq_in_msg, pay, 1'b1);
		if (pick < 55 && $urandom_range(3) == 0) begin
			cut = $urandom_range(frame.size() - 1);
			frame[cut] = frame[cut] ^ 8'($urandom_range(255, 1));
		end else if (pick >= 90 && pick < 95) begin
			cut = $urandom_range(frame.size(), 1);
			while (frame.size() > cut)
				void'(frame.pop_back());
		end else if (pick >= 95) begin
			frame.delete();
			repeat ($urandom_range(30, 1))
				frame.push_back(8'($urandom));
		end
		send_frame(seq);
	endtask

	task automatic run_traffic(input int min_bytes, input int min_results);
		int bytes0;
		int res0;
		bytes0 = sent_bytes;
		res0 = got_results;
		while (sent_bytes - bytes0 < min_bytes || got_results - res0 < min_results)
			send_random_frame();
	endtask

	task automatic set_echo_identifier(input logic [15:0] id);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ECHO_ID_ADDR;
		pwdata <= {16'($urandom), id};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		echo_id_m = id;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[15:0] !== id) begin
			$error("echo_identifier readback expected %0h actual %0h", id, prdata[15:0]);
			fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_directed();
		set_echo_identifier(16'h0000);
		send_idle_pct = 0;
		stall_pct = 0;
		// single-byte packets, largest and zero header length
		frame = {8'hFF};
		send_frame(16'hFFFF);
		frame = {8'h00};
		send_frame(16'h0000);
		// zero header length, header-only reply
		build_frame(0, ICMP_TYPE_ECHO_REPLY, 8'hFF, 16'h0000, 16'hFFFF, 0, 1'b1);
		send_frame(16'hFFFF);
		build_frame(1, ICMP_TYPE_TIME_EXCEEDED, 8'h00, 16'hFFFF, 16'h0000, 0, 1'b1);
		send_frame(16'h0000);
	endtask

	task automatic test_flat_out();
		set_echo_identifier(16'hFFFF);
		send_idle_pct = 0;
		stall_pct = 0;
		run_traffic(250, 6);
	endtask

	task automatic test_sender_gaps();
		set_echo_identifier(16'($urandom));
		send_idle_pct = 77;
		stall_pct = 0;
		run_traffic(250, 6);
	endtask

	task automatic test_receiver_stalls();
		set_echo_identifier(16'($urandom));
		send_idle_pct = 0;
		stall_pct = 77;
		run_traffic(250, 6);
	endtask

	task automatic test_both_idle();
		set_echo_identifier(16'h0000);
		send_idle_pct = 37;
		stall_pct = 37;
		run_traffic(250, 6);
	endtask

	task automatic test_backpressure();
		set_echo_identifier(16'($urandom));
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 400;
		repeat (40) begin
			frame.delete();
			repeat ($urandom_range(3, 1))
				frame.push_back(8'($urandom));
			send_frame(16'($urandom));
		end
		repeat (4) send_random_frame();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_flat_out();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();
		in_valid <= 1'b0;
		stall_pct = 0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
